// ===== design/bds_pkg.sv =====
// Shared types, widths, constants and codes for the band darkness steering block.
`timescale 1ns / 1ps

package bds_pkg;

    // Frame size limits; coordinates at or beyond these lie outside the window.
    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_LINES   = 1024;

    // Field widths.
    localparam int PIX_W    = 8;
    localparam int COORD_W  = 10;
    localparam int BW_W     = 9;
    localparam int RSTART_W = 10;
    localparam int REND_W   = 11;
    localparam int CNT_W    = 19;
    localparam int CODE_W   = 3;
    localparam int CIDX_W   = 3;
    localparam int CDATA_W  = 19;
    localparam int BAND_W   = 2;

    localparam logic [PIX_W-1:0] BRIGHT_LEVEL = PIX_W'(240);
    localparam logic [CNT_W-1:0] CNT_MAX      = {CNT_W{1'b1}};

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] REG_DARK_THRESHOLD = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] REG_BAND_WIDTH     = CIDX_W'(1);
    localparam logic [CIDX_W-1:0] REG_ROW_START      = CIDX_W'(2);
    localparam logic [CIDX_W-1:0] REG_ROW_END        = CIDX_W'(3);
    localparam logic [CIDX_W-1:0] REG_MIN_DARK_COUNT = CIDX_W'(4);
    localparam logic [CIDX_W-1:0] REG_NEAR_MARGIN    = CIDX_W'(5);

    // Register values after reset.
    localparam logic [PIX_W-1:0]    RST_DARK_THRESHOLD = PIX_W'(160);
    localparam logic [BW_W-1:0]     RST_BAND_WIDTH     = BW_W'(106);
    localparam logic [RSTART_W-1:0] RST_ROW_START      = RSTART_W'(106);
    localparam logic [REND_W-1:0]   RST_ROW_END        = REND_W'(240);
    localparam logic [CNT_W-1:0]    RST_MIN_DARK_COUNT = CNT_W'(2000);
    localparam logic [CNT_W-1:0]    RST_NEAR_MARGIN    = CNT_W'(1000);

    // Column band codes.
    localparam logic [BAND_W-1:0] BAND_LEFT   = BAND_W'(0);
    localparam logic [BAND_W-1:0] BAND_MIDDLE = BAND_W'(1);
    localparam logic [BAND_W-1:0] BAND_RIGHT  = BAND_W'(2);
    localparam logic [BAND_W-1:0] BAND_NONE   = BAND_W'(3);

    // Steering codes.
    localparam logic [CODE_W-1:0] STEER_UNCLEAR      = CODE_W'(0);
    localparam logic [CODE_W-1:0] STEER_LEFT_SLIGHT  = CODE_W'(1);
    localparam logic [CODE_W-1:0] STEER_LEFT         = CODE_W'(2);
    localparam logic [CODE_W-1:0] STEER_RIGHT_SLIGHT = CODE_W'(3);
    localparam logic [CODE_W-1:0] STEER_RIGHT        = CODE_W'(4);
    localparam logic [CODE_W-1:0] STEER_AHEAD        = CODE_W'(5);

    typedef struct packed {
        logic [PIX_W-1:0]    dark_threshold;
        logic [BW_W-1:0]     band_width;
        logic [RSTART_W-1:0] row_start;
        logic [REND_W-1:0]   row_end;
        logic [CNT_W-1:0]    min_dark_count;
        logic [CNT_W-1:0]    near_margin;
    } cfg_t;

    typedef struct packed {
        logic              in_window;
        logic              dark;
        logic [BAND_W-1:0] band;
    } class_t;

endpackage

// ===== design/bds_cfg_regs.sv =====
// Configuration register file of the band darkness steering block.
`timescale 1ns / 1ps

module bds_cfg_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         wr_en,
    input  logic [bds_pkg::CIDX_W-1:0]   wr_index,
    input  logic [bds_pkg::CDATA_W-1:0]  wr_data,
    output bds_pkg::cfg_t                cfg
);

    bds_pkg::cfg_t cfg_reg;
    bds_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (wr_index)
                bds_pkg::REG_DARK_THRESHOLD: begin
                    cfg_next.dark_threshold = wr_data[bds_pkg::PIX_W-1:0];
                end
                bds_pkg::REG_BAND_WIDTH: begin
                    cfg_next.band_width = wr_data[bds_pkg::BW_W-1:0];
                end
                bds_pkg::REG_ROW_START: begin
                    cfg_next.row_start = wr_data[bds_pkg::RSTART_W-1:0];
                end
                bds_pkg::REG_ROW_END: begin
                    cfg_next.row_end = wr_data[bds_pkg::REND_W-1:0];
                end
                bds_pkg::REG_MIN_DARK_COUNT: begin
                    cfg_next.min_dark_count = wr_data[bds_pkg::CNT_W-1:0];
                end
                bds_pkg::REG_NEAR_MARGIN: begin
                    cfg_next.near_margin = wr_data[bds_pkg::CNT_W-1:0];
                end
                default: begin
                    // Unknown indexes are ignored.
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dark_threshold <= bds_pkg::RST_DARK_THRESHOLD;
            cfg_reg.band_width     <= bds_pkg::RST_BAND_WIDTH;
            cfg_reg.row_start      <= bds_pkg::RST_ROW_START;
            cfg_reg.row_end        <= bds_pkg::RST_ROW_END;
            cfg_reg.min_dark_count <= bds_pkg::RST_MIN_DARK_COUNT;
            cfg_reg.near_margin    <= bds_pkg::RST_NEAR_MARGIN;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/bds_classify.sv =====
// Window and band classification of one pixel, with its darkness test.
`timescale 1ns / 1ps

module bds_classify (
    input  logic [bds_pkg::PIX_W-1:0]   pixel,
    input  logic [bds_pkg::COORD_W-1:0] column,
    input  logic [bds_pkg::COORD_W-1:0] line,
    input  bds_pkg::cfg_t               cfg,
    output bds_pkg::class_t             cls
);

    logic                          coord_ok;
    logic                          row_ok;
    logic [bds_pkg::COORD_W:0]     col_ext;
    logic [bds_pkg::COORD_W:0]     bw1;
    logic [bds_pkg::COORD_W:0]     bw2;
    logic [bds_pkg::COORD_W:0]     bw3;
    logic [bds_pkg::BAND_W-1:0]    band;

    // Band edges are band_width, twice it and three times it (shift and add).
    assign bw1     = (bds_pkg::COORD_W+1)'(cfg.band_width);
    assign bw2     = bw1 << 1;
    assign bw3     = bw2 + bw1;
    assign col_ext = {1'b0, column};

    assign coord_ok = (32'(column) < 32'(bds_pkg::MAX_COLUMNS))
                   && (32'(line) < 32'(bds_pkg::MAX_LINES));
    assign row_ok   = (line >= cfg.row_start)
                   && ((bds_pkg::REND_W)'(line) < cfg.row_end);

    always_comb begin
        band = bds_pkg::BAND_NONE;
        if (coord_ok && row_ok) begin
            if (col_ext < bw1) begin
                band = bds_pkg::BAND_LEFT;
            end else if (col_ext < bw2) begin
                band = bds_pkg::BAND_MIDDLE;
            end else if (col_ext < bw3) begin
                band = bds_pkg::BAND_RIGHT;
            end
        end
    end

    assign cls.band      = band;
    assign cls.in_window = (band != bds_pkg::BAND_NONE);
    assign cls.dark      = (band != bds_pkg::BAND_NONE) && (pixel < cfg.dark_threshold);

endmodule

// ===== design/bds_decide.sv =====
// Steering decision from the three band dark counts.
`timescale 1ns / 1ps

module bds_decide (
    input  logic [bds_pkg::CNT_W-1:0]  left_cnt,
    input  logic [bds_pkg::CNT_W-1:0]  middle_cnt,
    input  logic [bds_pkg::CNT_W-1:0]  right_cnt,
    input  bds_pkg::cfg_t              cfg,
    output logic [bds_pkg::CODE_W-1:0] code
);

    logic [bds_pkg::CNT_W-1:0] l_minus_m;
    logic [bds_pkg::CNT_W-1:0] r_minus_m;
    logic [bds_pkg::CNT_W-1:0] m_minus_l;
    logic [bds_pkg::CNT_W-1:0] m_minus_r;

    // Each difference is only used where it cannot go negative.
    assign l_minus_m = left_cnt - middle_cnt;
    assign r_minus_m = right_cnt - middle_cnt;
    assign m_minus_l = middle_cnt - left_cnt;
    assign m_minus_r = middle_cnt - right_cnt;

    always_comb begin
        if ((left_cnt < cfg.min_dark_count) && (middle_cnt < cfg.min_dark_count)
            && (right_cnt < cfg.min_dark_count)) begin
            code = bds_pkg::STEER_UNCLEAR;
        end else if ((left_cnt >= middle_cnt) && (left_cnt >= right_cnt)) begin
            code = (l_minus_m < cfg.near_margin) ? bds_pkg::STEER_LEFT_SLIGHT
                                                 : bds_pkg::STEER_LEFT;
        end else if (right_cnt > middle_cnt) begin
            code = (r_minus_m < cfg.near_margin) ? bds_pkg::STEER_RIGHT_SLIGHT
                                                 : bds_pkg::STEER_RIGHT;
        end else if (m_minus_l < cfg.near_margin) begin
            code = bds_pkg::STEER_LEFT_SLIGHT;
        end else if (m_minus_r < cfg.near_margin) begin
            code = bds_pkg::STEER_RIGHT_SLIGHT;
        end else begin
            code = bds_pkg::STEER_AHEAD;
        end
    end

endmodule

// ===== design/band_darkness_steering.sv =====
// Top level of the band darkness steering block: pipeline, band counters and outputs.
`timescale 1ns / 1ps

// Usage
// Grey pixels enter on the s_ channel in raster order, each transaction carrying the
// pixel value, its column and line, and a frame_end flag on the last pixel of a frame.
// Every input transaction produces exactly one result transaction on the m_ channel:
// the thresholded pixel (0 or 240), an in-window flag and, on the frame_end pixel, the
// steering code with the three band dark counts that produced it.
// The six configuration registers are written through the cfg_ channel, which is
// always ready; writes are meant to happen while no pixel is in flight.
// A transaction accepted on the s_ channel sits in the input register; once the output
// register is free, classification, the saturating band counters and the decision
// logic load the output register, which then presents the result with m_valid high.
// The block takes one pixel per clock while the receiver keeps m_ready high; the band
// counters update in the same cycle as the pixel moves into the output register.
// When the receiver stalls, the output register holds its result, the input register
// fills behind it and s_ready falls only when both stages are full.
// Reset (aresetn low, synchronous) empties both stages, zeroes the three counters and
// returns every configuration register to its default value.

module band_darkness_steering (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bds_pkg::PIX_W-1:0]     s_pixel,
    input  logic [bds_pkg::COORD_W-1:0]   s_column,
    input  logic [bds_pkg::COORD_W-1:0]   s_line,
    input  logic                          s_frame_end,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bds_pkg::PIX_W-1:0]     m_out_pixel,
    output logic                          m_in_window,
    output logic                          m_decision_valid,
    output logic [bds_pkg::CODE_W-1:0]    m_steer_code,
    output logic [bds_pkg::CNT_W-1:0]     m_left_dark,
    output logic [bds_pkg::CNT_W-1:0]     m_middle_dark,
    output logic [bds_pkg::CNT_W-1:0]     m_right_dark,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bds_pkg::CIDX_W-1:0]    cfg_index,
    input  logic [bds_pkg::CDATA_W-1:0]   cfg_data
);

    bds_pkg::cfg_t   cfg;
    bds_pkg::class_t cls;

    // Input register stage.
    logic                          in_valid_reg;
    logic [bds_pkg::PIX_W-1:0]     in_pixel_reg;
    logic [bds_pkg::COORD_W-1:0]   in_column_reg;
    logic [bds_pkg::COORD_W-1:0]   in_line_reg;
    logic                          in_frame_end_reg;

    // Output register stage.
    logic                          out_valid_reg;
    logic [bds_pkg::PIX_W-1:0]     out_pixel_reg;
    logic                          out_in_window_reg;
    logic                          out_decision_reg;
    logic [bds_pkg::CODE_W-1:0]    out_code_reg;
    logic [bds_pkg::CNT_W-1:0]     out_left_reg;
    logic [bds_pkg::CNT_W-1:0]     out_middle_reg;
    logic [bds_pkg::CNT_W-1:0]     out_right_reg;

    // Band counters.
    logic [bds_pkg::CNT_W-1:0]     left_count_reg;
    logic [bds_pkg::CNT_W-1:0]     middle_count_reg;
    logic [bds_pkg::CNT_W-1:0]     right_count_reg;
    logic [bds_pkg::CNT_W-1:0]     left_count_next;
    logic [bds_pkg::CNT_W-1:0]     middle_count_next;
    logic [bds_pkg::CNT_W-1:0]     right_count_next;

    logic [bds_pkg::CODE_W-1:0]    code;
    logic                          out_free;
    logic                          advance;
    logic                          s_take;

    assign cfg_ready = 1'b1;

    bds_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    bds_classify u_classify (
        .pixel  (in_pixel_reg),
        .column (in_column_reg),
        .line   (in_line_reg),
        .cfg    (cfg),
        .cls    (cls)
    );

    // Handshake: the output register is free when empty or being drained, and the
    // input register moves forward whenever the output register is free.
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign s_take   = s_valid && s_ready;

    // The count including the current pixel, saturating at the counter's maximum.
    always_comb begin
        left_count_next   = left_count_reg;
        middle_count_next = middle_count_reg;
        right_count_next  = right_count_reg;
        if (cls.dark) begin
            case (cls.band)
                bds_pkg::BAND_LEFT: begin
                    if (left_count_reg != bds_pkg::CNT_MAX) begin
                        left_count_next = left_count_reg + 1'b1;
                    end
                end
                bds_pkg::BAND_MIDDLE: begin
                    if (middle_count_reg != bds_pkg::CNT_MAX) begin
                        middle_count_next = middle_count_reg + 1'b1;
                    end
                end
                bds_pkg::BAND_RIGHT: begin
                    if (right_count_reg != bds_pkg::CNT_MAX) begin
                        right_count_next = right_count_reg + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    bds_decide u_decide (
        .left_cnt   (left_count_next),
        .middle_cnt (middle_count_next),
        .right_cnt  (right_count_next),
        .cfg        (cfg),
        .code       (code)
    );

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            left_count_reg   <= '0;
            middle_count_reg <= '0;
            right_count_reg  <= '0;
        end else begin
            if (s_take) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (advance) begin
                // The frame's last pixel hands its counts to the decision and clears them.
                if (in_frame_end_reg) begin
                    left_count_reg   <= '0;
                    middle_count_reg <= '0;
                    right_count_reg  <= '0;
                end else begin
                    left_count_reg   <= left_count_next;
                    middle_count_reg <= middle_count_next;
                    right_count_reg  <= right_count_next;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_pixel_reg     <= s_pixel;
            in_column_reg    <= s_column;
            in_line_reg      <= s_line;
            in_frame_end_reg <= s_frame_end;
        end
        if (advance) begin
            out_pixel_reg     <= (cls.in_window && !cls.dark) ? bds_pkg::BRIGHT_LEVEL : '0;
            out_in_window_reg <= cls.in_window;
            out_decision_reg  <= in_frame_end_reg;
            if (in_frame_end_reg) begin
                out_code_reg   <= code;
                out_left_reg   <= left_count_next;
                out_middle_reg <= middle_count_next;
                out_right_reg  <= right_count_next;
            end else begin
                out_code_reg   <= bds_pkg::STEER_UNCLEAR;
                out_left_reg   <= '0;
                out_middle_reg <= '0;
                out_right_reg  <= '0;
            end
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_out_pixel      = out_pixel_reg;
    assign m_in_window      = out_in_window_reg;
    assign m_decision_valid = out_decision_reg;
    assign m_steer_code     = out_code_reg;
    assign m_left_dark      = out_left_reg;
    assign m_middle_dark    = out_middle_reg;
    assign m_right_dark     = out_right_reg;

    // A result without a decision carries zero code and counts.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_decision_reg |->
            (out_code_reg == bds_pkg::STEER_UNCLEAR) && (out_left_reg == '0)
            && (out_middle_reg == '0) && (out_right_reg == '0))
        else $error("non-decision result carries decision data");

    // A pixel outside the window is always output as zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_in_window_reg |-> (out_pixel_reg == '0))
        else $error("pixel outside window not zero");

    // Moving a frame's last pixel forward leaves all counters cleared.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_frame_end_reg |=>
            (left_count_reg == '0) && (middle_count_reg == '0) && (right_count_reg == '0))
        else $error("counters not cleared after frame end");

    // The input side stalls only when both stages are full and the receiver waits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled with free pipeline space");

    // Counters only change when an item moves forward.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(left_count_reg) && $stable(middle_count_reg)
            && $stable(right_count_reg))
        else $error("counter changed without an item");

endmodule
